// ----- sv/iptp_pkg.sv -----
`timescale 1ns / 1ps
package iptp_pkg;

  localparam int MaxTextLen = 64;
  localparam int NumWords = 8;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot = 8'h2E;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  // One input character request.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  // One parse result.
  typedef struct packed {
    logic        addr_valid;
    logic        is_ipv6;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [31:0] zone_index;
  } out_item_t;

  // Decoded character classes.
  typedef struct packed {
    logic       is_digit;
    logic       is_hex;
    logic [3:0] hex_value;
    logic       is_colon;
    logic       is_dot;
    logic       is_percent;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r = '0;
    r.is_digit = (c >= ChZero) && (c <= ChNine);
    r.is_colon = (c == ChColon);
    r.is_dot = (c == ChDot);
    r.is_percent = (c == ChPercent);
    if (r.is_digit) begin
      r.is_hex = 1'b1;
      r.hex_value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.is_hex = 1'b1;
      r.hex_value = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

// ----- sv/iptp_stream_if.sv -----
`timescale 1ns / 1ps
interface iptp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/ip_address_text_parser_core.sv -----
`timescale 1ns / 1ps
// Streaming IPv4/IPv6 address text parser. Send one character per request with
// end_of_text low, then one request with end_of_text high; that request yields
// one result (valid flag, family, 128-bit address, zone) and clears the parse
// state. A character is taken every cycle while the output buffer has room; the
// scanner forms the result combinationally, and the two-entry output buffer
// (result register and skid entry) keeps input flowing while a result waits.
module ip_address_text_parser_core #(
  parameter int MAX_TEXT_LEN = iptp_pkg::MaxTextLen
) (
  input  logic          clk,
  input  logic          rst,
  iptp_stream_if.sink   in_ch,
  iptp_stream_if.source out_ch
);
  import iptp_pkg::*;

  logic      space, step;
  out_item_t result;

  assign in_ch.ready = space;
  assign step = in_ch.valid && space;

  iptp_scan #(.MAX_TEXT_LEN(MAX_TEXT_LEN)) u_scan (
    .clk(clk), .rst(rst), .step(step), .item(in_ch.payload), .result(result)
  );

  iptp_out_reg u_out (
    .clk(clk), .rst(rst), .load(step && in_ch.payload.end_of_text),
    .data(result), .space(space), .out_ch(out_ch)
  );

  // After an end request, the output must show a valid result in the next cycle.
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    step && in_ch.payload.end_of_text |=> out_ch.valid)
    else $error("end request gave no result");

  // An invalid result carries all-zero fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.payload.addr_valid |->
      (out_ch.payload.address_low == '0 && out_ch.payload.zone_index == '0 &&
       !out_ch.payload.is_ipv6))
    else $error("invalid result has nonzero fields");

  // IPv4 results have no high half and no zone.
  a_v4_shape: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.payload.is_ipv6 |->
      (out_ch.payload.address_high == '0 && out_ch.payload.address_low[63:32] == '0))
    else $error("IPv4 result out of shape");

endmodule

// ----- sv/iptp_scan.sv -----
`timescale 1ns / 1ps
// Character scanner: holds the parse state and produces the result on an end request.
module iptp_scan #(
  parameter int MAX_TEXT_LEN = iptp_pkg::MaxTextLen
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  iptp_pkg::in_item_t   item,
  output iptp_pkg::out_item_t  result
);
  import iptp_pkg::*;

  localparam int LenW = $clog2(MAX_TEXT_LEN + 2);

  logic [LenW-1:0] text_length;
  logic        any_colon, in_zone, zone_digits_seen;
  logic [31:0] zone_value;
  logic [31:0] octet_bytes;
  logic [1:0]  octet_index;
  logic [9:0]  octet_value;
  logic [1:0]  octet_digits;
  logic [15:0] group_words [NumWords];
  logic [3:0]  word_count, left_count;
  logic        compress_seen;
  logic [15:0] group_value;
  logic [2:0]  group_digits;
  logic        group_dotted, prev_colon, v4_error, v6_error;

  logic [LenW-1:0] text_length_next;
  logic        any_colon_next, in_zone_next, zone_digits_seen_next;
  logic [31:0] zone_value_next;
  logic [31:0] octet_bytes_next;
  logic [1:0]  octet_index_next;
  logic [9:0]  octet_value_next;
  logic [1:0]  octet_digits_next;
  logic [15:0] group_words_next [NumWords];
  logic [3:0]  word_count_next, left_count_next;
  logic        compress_seen_next;
  logic [15:0] group_value_next;
  logic [2:0]  group_digits_next;
  logic        group_dotted_next, prev_colon_next, v4_error_next, v6_error_next;

  char_class_t cc;
  logic [35:0] zone_wide;
  logic [31:0] fin_bytes;
  logic        fin_ok, dotted_good;
  logic        close_now, close_colon, do_close, end_addr;
  logic        len_ok, count_ok, ok6;
  logic [15:0] w [NumWords];
  logic [3:0]  r_cnt;
  logic [3:0]  src;
  out_item_t   res;

  assign cc = classify(item.char_code);
  assign zone_wide = {4'd0, zone_value} * 36'd10 + {32'd0, item.char_code[3:0]};

  // Current octet folded into the octet word.
  always_comb begin
    fin_ok = (octet_digits != 2'd0) && (octet_value <= 10'd255);
    fin_bytes = octet_bytes;
    unique case (octet_index)
      2'd0: fin_bytes[31:24] = octet_value[7:0];
      2'd1: fin_bytes[23:16] = octet_value[7:0];
      2'd2: fin_bytes[15:8]  = octet_value[7:0];
      default: fin_bytes[7:0] = octet_value[7:0];
    endcase
    dotted_good = !v4_error && (octet_index == 2'd3) && fin_ok;
  end

  // Next state for one character.
  always_comb begin
    text_length_next = text_length;
    any_colon_next = any_colon;
    in_zone_next = in_zone;
    zone_digits_seen_next = zone_digits_seen;
    zone_value_next = zone_value;
    octet_bytes_next = octet_bytes;
    octet_index_next = octet_index;
    octet_value_next = octet_value;
    octet_digits_next = octet_digits;
    for (int i = 0; i < NumWords; i++) group_words_next[i] = group_words[i];
    word_count_next = word_count;
    left_count_next = left_count;
    compress_seen_next = compress_seen;
    group_value_next = group_value;
    group_digits_next = group_digits;
    group_dotted_next = group_dotted;
    prev_colon_next = prev_colon;
    v4_error_next = v4_error;
    v6_error_next = v6_error;
    close_now = (group_digits != 3'd0) || group_dotted;
    close_colon = 1'b0;
    do_close = 1'b0;
    end_addr = 1'b0;

    if (!item.end_of_text) begin
      if (text_length < LenW'(MAX_TEXT_LEN + 1)) text_length_next = text_length + 1'b1;
      if (cc.is_colon) any_colon_next = 1'b1;
      if (in_zone) begin
        if (cc.is_digit) begin
          if (zone_wide[35:32] != 4'd0) v6_error_next = 1'b1;
          else zone_value_next = zone_wide[31:0];
        end else begin
          v6_error_next = 1'b1;
        end
        zone_digits_seen_next = 1'b1;
      end else if (cc.is_percent) begin
        end_addr = 1'b1;
        in_zone_next = 1'b1;
      end else if (cc.is_colon) begin
        if (close_now) begin
          do_close = 1'b1;
          close_colon = 1'b1;
        end else if (prev_colon) begin
          if (compress_seen) v6_error_next = 1'b1;
          else begin
            compress_seen_next = 1'b1;
            left_count_next = word_count;
          end
        end
        prev_colon_next = 1'b1;
      end else begin
        if (prev_colon && word_count == 4'd0 && !compress_seen) v6_error_next = 1'b1;
        prev_colon_next = 1'b0;
        // Dotted octet tracking.
        if (cc.is_digit) begin
          if (octet_digits == 2'd3 || (octet_digits == 2'd1 && octet_value == 10'd0))
            v4_error_next = 1'b1;
          else begin
            octet_value_next = octet_value * 10'd10 + {6'd0, cc.hex_value};
            octet_digits_next = octet_digits + 2'd1;
          end
        end else if (cc.is_dot) begin
          if (!fin_ok || octet_index == 2'd3) v4_error_next = 1'b1;
          else begin
            octet_bytes_next = fin_bytes;
            octet_index_next = octet_index + 2'd1;
          end
          octet_value_next = '0;
          octet_digits_next = '0;
        end else begin
          v4_error_next = 1'b1;
        end
        // Hex group tracking.
        if (cc.is_hex) begin
          group_value_next = {group_value[11:0], cc.hex_value};
          if (group_digits < 3'd5) group_digits_next = group_digits + 3'd1;
        end else if (cc.is_dot) begin
          group_dotted_next = 1'b1;
        end else begin
          v6_error_next = 1'b1;
        end
      end
    end else begin
      if (!in_zone) end_addr = 1'b1;
    end

    // End of the address part closes the open group or checks a trailing colon.
    if (end_addr) begin
      if (close_now) do_close = 1'b1;
      else if (prev_colon && !(compress_seen && word_count == left_count))
        v6_error_next = 1'b1;
    end

    // Group close: store one hex word or two dotted words.
    if (do_close) begin
      if (group_dotted) begin
        if (close_colon || !dotted_good || word_count > 4'd6) v6_error_next = 1'b1;
        else begin
          group_words_next[word_count[2:0]] = fin_bytes[31:16];
          group_words_next[3'(word_count + 4'd1)] = fin_bytes[15:0];
          word_count_next = word_count + 4'd2;
        end
      end else if (group_digits > 3'd4) begin
        v6_error_next = 1'b1;
      end else if (word_count >= 4'd8) begin
        v6_error_next = 1'b1;
      end else begin
        group_words_next[word_count[2:0]] = group_value;
        word_count_next = word_count + 4'd1;
      end
      group_value_next = '0;
      group_digits_next = '0;
      group_dotted_next = 1'b0;
    end

    // A colon or percent restarts the dotted tracking.
    if (!item.end_of_text && !in_zone && (cc.is_colon || cc.is_percent)) begin
      octet_bytes_next = '0;
      octet_index_next = '0;
      octet_value_next = '0;
      octet_digits_next = '0;
      v4_error_next = cc.is_percent;
    end
    if (!item.end_of_text && in_zone == 1'b0 && cc.is_percent) v4_error_next = 1'b1;
    if (item.end_of_text && in_zone && !zone_digits_seen) v6_error_next = 1'b1;
  end

  // Result assembly, with the compressed run expanded.
  always_comb begin
    len_ok = (text_length != '0) && (text_length <= LenW'(MAX_TEXT_LEN));
    count_ok = compress_seen ? (word_count_next <= 4'd7) : (word_count_next == 4'd8);
    ok6 = len_ok && !v6_error_next && count_ok;
    r_cnt = word_count_next - left_count;
    for (int i = 0; i < NumWords; i++) begin
      w[i] = '0;
      src = 4'(i);
      if (!compress_seen) w[i] = group_words_next[i];
      else if (4'(i) < left_count) w[i] = group_words_next[i];
      else if (4'(i) >= 4'd8 - r_cnt) begin
        src = 4'(i) - (4'd8 - r_cnt) + left_count;
        w[i] = group_words_next[src[2:0]];
      end
    end
    res = '0;
    if (!any_colon) begin
      if (len_ok && !in_zone && dotted_good) begin
        res.addr_valid = 1'b1;
        res.address_low = {32'd0, fin_bytes};
      end
    end else if (ok6) begin
      res.addr_valid = 1'b1;
      res.is_ipv6 = 1'b1;
      res.address_high = {w[0], w[1], w[2], w[3]};
      res.address_low = {w[4], w[5], w[6], w[7]};
      res.zone_index = zone_value;
    end
  end

  assign result = res;

  // State registers; an end request clears everything.
  always_ff @(posedge clk) begin
    if (rst || (step && item.end_of_text)) begin
      text_length <= '0;
      any_colon <= 1'b0;
      in_zone <= 1'b0;
      zone_digits_seen <= 1'b0;
      zone_value <= '0;
      octet_bytes <= '0;
      octet_index <= '0;
      octet_value <= '0;
      octet_digits <= '0;
      for (int i = 0; i < NumWords; i++) group_words[i] <= '0;
      word_count <= '0;
      left_count <= '0;
      compress_seen <= 1'b0;
      group_value <= '0;
      group_digits <= '0;
      group_dotted <= 1'b0;
      prev_colon <= 1'b0;
      v4_error <= 1'b0;
      v6_error <= 1'b0;
    end else if (step) begin
      text_length <= text_length_next;
      any_colon <= any_colon_next;
      in_zone <= in_zone_next;
      zone_digits_seen <= zone_digits_seen_next;
      zone_value <= zone_value_next;
      octet_bytes <= octet_bytes_next;
      octet_index <= octet_index_next;
      octet_value <= octet_value_next;
      octet_digits <= octet_digits_next;
      for (int i = 0; i < NumWords; i++) group_words[i] <= group_words_next[i];
      word_count <= word_count_next;
      left_count <= left_count_next;
      compress_seen <= compress_seen_next;
      group_value <= group_value_next;
      group_digits <= group_digits_next;
      group_dotted <= group_dotted_next;
      prev_colon <= prev_colon_next;
      v4_error <= v4_error_next;
      v6_error <= v6_error_next;
    end
  end

endmodule

// ----- sv/iptp_out_reg.sv -----
`timescale 1ns / 1ps
// Result register with a skid stage, so input is taken while a result waits.
module iptp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  iptp_pkg::out_item_t data,
  output logic                space,
  iptp_stream_if.source       out_ch
);
  import iptp_pkg::*;

  logic      main_valid, skid_valid;
  out_item_t main_data, skid_data;
  logic      pop;

  assign pop = main_valid && out_ch.ready;
  assign space = !skid_valid;
  assign out_ch.valid = main_valid;
  assign out_ch.payload = main_data;

  // Control: main holds the oldest result, skid the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!main_valid || pop) begin
        main_valid <= skid_valid || load;
        skid_valid <= skid_valid && load;
      end else if (load) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload movement.
  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      if (skid_valid) main_data <= skid_data;
      else if (load) main_data <= data;
    end
    if (load && (skid_valid || (main_valid && !pop))) skid_data <= data;
  end

endmodule

// ----- verif/ip_address_text_parser_core_test.sv -----
`timescale 1ns / 1ps
module ip_address_text_parser_core_test;
  import iptp_pkg::*;

  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  iptp_stream_if #(.payload_t(in_item_t)) in_ch ();
  iptp_stream_if #(.payload_t(out_item_t)) out_ch ();

  ip_address_text_parser_core uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state of the predictor.
  int unsigned p_len;
  bit p_colon, p_zone, p_zdig, p_oerr, p_gerr, p_comp, p_dotted, p_prev;
  bit [31:0] p_zval, p_obytes;
  int unsigned p_oidx, p_oval, p_odig, p_wcnt, p_lcnt, p_gval, p_gdig;
  bit [15:0] p_words[NumWords];

  out_item_t parse_results[$];
  int errors = 0;
  bit finish_stim = 1'b0;
  bit hold_long = 1'b0;
  bit calm = 1'b0;
  int idle_cycles = 0;

  function automatic void clear_parser();
    p_len = 0; p_colon = 0; p_zone = 0; p_zval = 0; p_zdig = 0;
    p_obytes = 0; p_oidx = 0; p_oval = 0; p_odig = 0; p_oerr = 0;
    foreach (p_words[i]) p_words[i] = '0;
    p_wcnt = 0; p_lcnt = 0; p_comp = 0; p_gval = 0; p_gdig = 0;
    p_dotted = 0; p_prev = 0; p_gerr = 0;
  endfunction

  function automatic bit octet_done();
    int unsigned sh;
    if (p_odig == 0 || p_oval > 255) return 1'b0;
    sh = (3 - (p_oidx & 3)) * 8;
    p_obytes = (p_obytes & ~(32'hFF << sh)) | (32'(p_oval) << sh);
    return 1'b1;
  endfunction

  function automatic bit quad_ok();
    return !p_oerr && p_oidx == 3 && octet_done();
  endfunction

  function automatic void push_word(bit [15:0] w);
    if (p_wcnt >= 8) begin
      p_gerr = 1;
      return;
    end
    p_words[p_wcnt & 7] = w;
    p_wcnt++;
  endfunction

  function automatic void close_group(bit by_colon);
    if (p_dotted) begin
      if (by_colon || !quad_ok() || p_wcnt > 6) p_gerr = 1;
      else begin
        push_word(p_obytes[31:16]);
        push_word(p_obytes[15:0]);
      end
    end else if (p_gdig > 4) p_gerr = 1;
    else push_word(p_gval[15:0]);
    p_gval = 0; p_gdig = 0; p_dotted = 0;
  endfunction

  function automatic void close_address();
    if (p_gdig > 0 || p_dotted) close_group(1'b0);
    else if (p_prev && !(p_comp && p_wcnt == p_lcnt)) p_gerr = 1;
  endfunction

  // Advances the predictor by one character.
  function automatic void scan_char(bit [7:0] c);
    int h;
    bit [35:0] nz;
    if (p_len < MaxTextLen + 1) p_len++;
    if (c == ChColon) p_colon = 1;
    if (p_zone) begin
      if (c >= ChZero && c <= ChNine) begin
        nz = 36'(p_zval) * 36'd10 + 36'(c - ChZero);
        if (nz > 36'hFFFFFFFF) p_gerr = 1;
        else p_zval = nz[31:0];
      end else p_gerr = 1;
      p_zdig = 1;
      return;
    end
    if (c == ChPercent) begin
      close_address();
      p_zone = 1; p_oerr = 1;
      return;
    end
    if (c == ChColon) begin
      if (p_gdig > 0 || p_dotted) close_group(1'b1);
      else if (p_prev) begin
        if (p_comp) p_gerr = 1;
        else begin
          p_comp = 1; p_lcnt = p_wcnt;
        end
      end
      p_prev = 1;
      p_obytes = 0; p_oidx = 0; p_oval = 0; p_odig = 0; p_oerr = 0;
      return;
    end
    if (p_prev && p_wcnt == 0 && !p_comp) p_gerr = 1;
    p_prev = 0;
    if (c >= ChZero && c <= ChNine) begin
      if (p_odig >= 3 || (p_odig == 1 && p_oval == 0)) p_oerr = 1;
      else begin
        p_oval = p_oval * 10 + (c - ChZero);
        p_odig++;
      end
    end else if (c == ChDot) begin
      if (!octet_done() || p_oidx >= 3) p_oerr = 1;
      else p_oidx++;
      p_oval = 0; p_odig = 0;
    end else p_oerr = 1;
    if (c >= "0" && c <= "9") h = c - "0";
    else if (c >= "a" && c <= "f") h = c - "a" + 10;
    else if (c >= "A" && c <= "F") h = c - "A" + 10;
    else h = -1;
    if (h >= 0) begin
      p_gval = ((p_gval << 4) | h) & 16'hFFFF;
      if (p_gdig < 5) p_gdig++;
    end else if (c == ChDot) p_dotted = 1;
    else p_gerr = 1;
  endfunction

  // Result of an end request; clears the parser afterwards.
  function automatic out_item_t finish_text();
    out_item_t r;
    bit len_ok, cnt_ok;
    bit [15:0] w[NumWords];
    int unsigned rest;
    r = '0;
    len_ok = p_len > 0 && p_len <= MaxTextLen;
    if (!p_colon) begin
      if (len_ok && !p_zone && quad_ok()) begin
        r.addr_valid = 1; r.address_low = {32'h0, p_obytes};
      end
    end else begin
      if (!p_zone) close_address();
      else if (!p_zdig) p_gerr = 1;
      cnt_ok = p_comp ? (p_wcnt <= 7) : (p_wcnt == 8);
      if (len_ok && !p_gerr && cnt_ok) begin
        foreach (w[i]) w[i] = '0;
        if (p_comp) begin
          rest = p_wcnt - p_lcnt;
          for (int i = 0; i < p_lcnt && i < 8; i++) w[i] = p_words[i];
          for (int k = 0; k < rest && k < 8; k++)
            w[(8 - rest + k) & 7] = p_words[(p_lcnt + k) & 7];
        end else w = p_words;
        r.address_high = {w[0], w[1], w[2], w[3]};
        r.address_low = {w[4], w[5], w[6], w[7]};
        r.addr_valid = 1; r.is_ipv6 = 1; r.zone_index = p_zval;
      end
    end
    clear_parser();
    return r;
  endfunction

  // Directed texts; the expected result is given where it is plain.
  typedef struct {
    string txt;
    bit known;
    out_item_t res;
  } text_row_t;

  text_row_t rows[$];

  function automatic out_item_t v4_res(bit [31:0] a);
    out_item_t r;
    r = '0; r.addr_valid = 1; r.address_low = {32'h0, a};
    return r;
  endfunction

  function automatic string rand_text();
    string s;
    string hexd;
    string punct;
    int kind, n;
    hexd = "0123456789abcdefABCDEF";
    punct = ":.%0aF";
    s = "";
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      for (int i = 0; i < 4; i++) begin
        s = {s, $sformatf("%0d", $urandom_range(0, (kind == 0) ? 300 : 255))};
        if (i < 3) s = {s, "."};
      end
    end else if (kind < 8) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        for (int d = $urandom_range(1, (kind == 3) ? 5 : 4); d > 0; d--)
          s = {s, string'(hexd[$urandom_range(0, 21)])};
        if (i < n - 1) s = {s, ($urandom_range(0, 9) == 0) ? "::" : ":"};
      end
      if ($urandom_range(0, 3) == 0) s = {"::", s};
      if ($urandom_range(0, 4) == 0) s = {s, ":1.2.3.", $sformatf("%0d", $urandom_range(0, 260))};
      if ($urandom_range(0, 3) == 0) s = {s, "%", $sformatf("%0d", $urandom)};
      if ($urandom_range(0, 9) == 0) s = {s, "9"};
    end else begin
      n = $urandom_range(0, (kind == 8) ? 12 : 70);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 1)) s = {s, string'(byte'($urandom_range(0, 255)))};
        else s = {s, string'(punct[$urandom_range(0, 5)])};
      end
    end
    return s;
  endfunction

  // Sends one request once the block takes it.
  task automatic send_req(bit [7:0] c, bit eot);
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{char_code: c, end_of_text: eot};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (eot) parse_results.push_back(finish_text());
    else scan_char(c);
  endtask

  task automatic idle_in();
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= in_item_t'(9'($urandom));
      n = $urandom_range(1, 17);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_text(string s, bit known, out_item_t res);
    for (int i = 0; i < s.len(); i++) begin
      idle_in();
      send_req(s[i], 1'b0);
    end
    idle_in();
    send_req(8'($urandom), 1'b1);
    // The newest prediction stays at the back until its result comes out.
    if (known && parse_results[$] != res) begin
      $display("%t directed row \"%s\": table %h, model %h", $time, s, res,
               parse_results[$]);
      errors++;
    end
  endtask

  // Stimulus.
  initial begin
    out_item_t z;
    string s;
    z = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    clear_parser();
    rows.push_back('{"", 1, z});
    rows.push_back('{"0.0.0.0", 1, v4_res(32'h0)});
    rows.push_back('{"255.255.255.255", 1, v4_res(32'hFFFFFFFF)});
    rows.push_back('{"256.1.1.1", 1, z});
    rows.push_back('{"01.2.3.4", 1, z});
    rows.push_back('{"1.2.3", 1, z});
    rows.push_back('{"1.2.3.4%1", 1, z});
    rows.push_back('{"::", 0, z});
    rows.push_back('{"::1", 0, z});
    rows.push_back('{"ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff", 0, z});
    rows.push_back('{"1:2:3:4:5:6:7:8:9", 1, z});
    rows.push_back('{"1::2::3", 1, z});
    rows.push_back('{"::ffff:192.168.1.1", 0, z});
    rows.push_back('{"1:2:3:4:5:6:7:1.2.3.4", 1, z});
    rows.push_back('{"fe80::1%4294967295", 0, z});
    rows.push_back('{"fe80::1%4294967296", 1, z});
    rows.push_back('{"fe80::1%", 1, z});
    rows.push_back('{"fe80::1%1:2", 1, z});
    rows.push_back('{"fe80::1%x", 1, z});
    rows.push_back('{"12345::", 1, z});
    rows.push_back('{":1:2:3:4:5:6:7", 1, z});
    rows.push_back('{"1:2:3:4:5:6:7:", 1, z});
    rows.push_back('{"0000:0000:0000:0000:0000:0000:0000:00000000000000000000000", 1, z});
    rows.push_back('{"a:b:c:d:e:f:0:1", 0, z});
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_text(rows[i].txt, rows[i].known, rows[i].res);
    // Long receiver hold-off while requests keep coming.
    hold_long <= 1'b1;
    for (int i = 0; i < 12; i++) begin
      s = "1.2.3.4";
      send_text(s, 0, z);
    end
    hold_long <= 1'b0;
    // Random texts.
    for (int i = 0; i < 32; i++) begin
      if (i == 16) begin
        in_ch.valid <= 1'b0;
        while (parse_results.size() != 0) @(posedge clk);
      end
      if (i == 24) calm = 1'b1;
      send_text(rand_text(), 0, z);
    end
    in_ch.valid <= 1'b0;
    finish_stim <= 1'b1;
  end

  // Receiver with random and long stalls.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result checking.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (parse_results.size() == 0) begin
        $display("%t unexpected result %h", $time, out_ch.payload);
        errors++;
      end else begin
        want = parse_results.pop_front();
        if (out_ch.payload.addr_valid !== want.addr_valid ||
            out_ch.payload.is_ipv6 !== want.is_ipv6 ||
            out_ch.payload.address_high !== want.address_high ||
            out_ch.payload.address_low !== want.address_low ||
            out_ch.payload.zone_index !== want.zone_index) begin
          $display("%t mismatch: expected %h, actual %h", $time, want, out_ch.payload);
          errors++;
        end
      end
    end
  end

  // Watchdog and end of run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    fork
      begin
        @(posedge finish_stim);
        while (parse_results.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
      end
      begin
        while (idle_cycles < WatchLimit) @(posedge clk);
        errors++;
      end
    join_any
    if (errors == 0) $display("ip_address_text_parser_core verification clean");
    else $display("ip_address_text_parser_core verification failed");
    $finish;
  end

endmodule
